// File: rtl/tbp_pkg.sv
// ----------------------------------------------------------------------------
// Token bucket policer package
// Shared widths, reciprocal constants, verdict codes and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package tbp_pkg;

	localparam int RULE_IDX_W     = 8;
	localparam int RULE_SPAN      = 1 << RULE_IDX_W;
	localparam int RULE_COUNT_DEF = 256;

	localparam int RATE_W = 40;
	localparam int TIME_W = 64;
	localparam int LEN_W  = 16;
	localparam int TOK_W  = 38;
	localparam int CAP_W  = 37;

	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 8;

	localparam logic [TIME_W-1:0] NS_PER_SEC = 64'd1000000000;
	localparam int EL_W = 30;

	// elapsed / 1000 = (elapsed >> 3) / 125, by reciprocal
	localparam int ELX_W   = 27;
	localparam int RCP1_W  = 28;
	localparam logic [RCP1_W-1:0] RECIP1 = 28'd137438954;
	localparam int SHIFT1  = 34;
	localparam int PROD1_W = ELX_W + RCP1_W;
	localparam int Q1_W    = 20;

	// (rate / 8) / 1000 = (rate >> 6) / 125, split in two partial products
	localparam int CAPX_W    = 34;
	localparam int CAPX_LO_W = 17;
	localparam int CAPX_HI_W = CAPX_W - CAPX_LO_W;
	localparam int RCP2_W    = 35;
	localparam logic [RCP2_W-1:0] RECIP2 = 35'd17592186045;
	localparam int SHIFT2    = 41;
	localparam int PP2_W     = CAPX_LO_W + RCP2_W;
	localparam int SUM2_W    = CAPX_W + RCP2_W + 1;
	localparam int Q2_W      = 28;

	localparam int PROD_W = Q1_W + Q2_W;

	// product / 1000000 = (product >> 6) / 15625, split in two partial products
	localparam int PX_W    = 41;
	localparam int PX_LO_W = 21;
	localparam int PX_HI_W = PX_W - PX_LO_W;
	localparam int RCP3_W  = 42;
	localparam logic [RCP3_W-1:0] RECIP3 = 42'd2305843009214;
	localparam int SHIFT3  = 55;
	localparam int PPL3_W  = PX_LO_W + RCP3_W;
	localparam int PPH3_W  = PX_HI_W + RCP3_W;
	localparam int SUM3_W  = PX_W + RCP3_W + 1;
	localparam int REFILL_W = 28;

	typedef enum logic [1:0] {
		CAUSE_FIRST = 2'd0,
		CAUSE_PASS  = 2'd1,
		CAUSE_DROP  = 2'd2
	} cause_t;

	typedef struct packed {
		logic [TOK_W-1:0]  tokens;
		logic [TIME_W-1:0] last_time;
		logic [RATE_W-1:0] rate;
	} bucket_t;

	typedef struct packed {
		logic load;
		logic calc_elapsed;
		logic calc_mul;
		logic calc_quot;
		logic calc_prod;
		logic calc_div;
		logic calc_refill;
		logic calc_clamp;
		logic wr_init;
		logic wr_verdict;
	} dp_cmd_t;

	typedef struct packed {
		logic bucket_valid;
	} dp_status_t;

endpackage

// File: rtl/tbp_datapath.sv
// ----------------------------------------------------------------------------
// Token bucket policer datapath
// Request capture, bucket memory with per-rule valid bits, and the refill
// arithmetic done as a chain of registered multiply and shift steps.
// ----------------------------------------------------------------------------
module tbp_datapath #(
	parameter int RULE_COUNT = tbp_pkg::RULE_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tbp_pkg::dp_cmd_t                 cmd,
	input  logic [tbp_pkg::IN_TDATA_W-1:0]   in_tdata,
	output tbp_pkg::dp_status_t              status,
	output logic                             res_pass,
	output tbp_pkg::cause_t                  res_cause
);
	import tbp_pkg::*;

	localparam int DEPTH  = (RULE_COUNT < RULE_SPAN) ? RULE_COUNT : RULE_SPAN;
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// rule index to slot, wrapping modulo the rule count
	logic [SLOT_W-1:0] slot_lut [RULE_SPAN];
	for (genvar g = 0; g < RULE_SPAN; g++) begin : g_slot
		assign slot_lut[g] = SLOT_W'(g % RULE_COUNT);
	end

	logic [RULE_IDX_W-1:0] in_rule;
	logic [RATE_W-1:0]     in_rate;
	logic [TIME_W-1:0]     in_now;
	logic [LEN_W-1:0]      in_len;
	logic [SLOT_W-1:0]     in_slot;

	assign in_rule = in_tdata[7:0];
	assign in_rate = in_tdata[47:8];
	assign in_now  = in_tdata[111:48];
	assign in_len  = in_tdata[127:112];
	assign in_slot = slot_lut[in_rule];

	logic [SLOT_W-1:0]   slot_q;
	logic [RATE_W-1:0]   rate_in_q;
	logic [TIME_W-1:0]   now_q;
	logic [LEN_W-1:0]    len_q;
	bucket_t             rd_q;
	bucket_t             bucket_mem_q [DEPTH];
	logic [DEPTH-1:0]    valid_q;

	logic [ELX_W-1:0]    elx_q;
	logic [PROD1_W-1:0]  prod1_q;
	logic [PP2_W-1:0]    pl_q;
	logic [PP2_W-1:0]    ph_q;
	logic [Q1_W-1:0]     q1_q;
	logic [Q2_W-1:0]     q2_q;
	logic [PROD_W-1:0]   p_q;
	logic [PPL3_W-1:0]   dl_q;
	logic [PPH3_W-1:0]   dh_q;
	logic [REFILL_W-1:0] refill_q;
	logic [CAP_W-1:0]    tok_new_q;

	logic [TIME_W-1:0]   diff;
	logic [EL_W-1:0]     el_clamp;
	logic [CAPX_W-1:0]   capx;
	logic [CAP_W-1:0]    cap;
	logic [SUM2_W-1:0]   sum2;
	logic [PX_W-1:0]     px;
	logic [SUM3_W-1:0]   sum3;
	logic [TOK_W:0]      tok_sum;
	logic                fits;
	logic                mem_we;
	bucket_t             wdata;

	assign diff     = now_q - rd_q.last_time;
	assign el_clamp = (diff > NS_PER_SEC) ? EL_W'(NS_PER_SEC) : diff[EL_W-1:0];
	assign capx     = rd_q.rate[RATE_W-1:6];
	assign cap      = rd_q.rate[RATE_W-1:3];
	assign sum2     = SUM2_W'(pl_q) + (SUM2_W'(ph_q) << CAPX_LO_W);
	assign px       = p_q[6 +: PX_W];
	assign sum3     = SUM3_W'(dl_q) + (SUM3_W'(dh_q) << PX_LO_W);
	assign tok_sum  = (TOK_W + 1)'(rd_q.tokens) + (TOK_W + 1)'(refill_q);
	assign fits     = tok_new_q >= CAP_W'(len_q);
	assign mem_we   = cmd.wr_init | cmd.wr_verdict;

	always_comb begin
		if (cmd.wr_init) begin
			wdata.tokens = TOK_W'(rate_in_q[RATE_W-1:3]);
			wdata.rate   = rate_in_q;
		end else begin
			wdata.tokens = fits ? TOK_W'(tok_new_q - CAP_W'(len_q)) : TOK_W'(tok_new_q);
			wdata.rate   = rd_q.rate;
		end
		wdata.last_time = now_q;
	end

	always_comb begin
		if (cmd.wr_init) begin
			res_pass  = 1'b1;
			res_cause = CAUSE_FIRST;
		end else if (fits) begin
			res_pass  = 1'b1;
			res_cause = CAUSE_PASS;
		end else begin
			res_pass  = 1'b0;
			res_cause = CAUSE_DROP;
		end
	end

	assign status.bucket_valid = valid_q[slot_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_init) begin
			valid_q[slot_q] <= 1'b1;
		end
	end

	// single-port bucket store, read at request accept, written at first-packet init or at the verdict
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bucket_mem_q[slot_q] <= wdata;
		end
		if (cmd.load) begin
			rd_q <= bucket_mem_q[in_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q    <= in_slot;
			rate_in_q <= in_rate;
			now_q     <= in_now;
			len_q     <= in_len;
		end
		if (cmd.calc_elapsed) begin
			elx_q <= el_clamp[EL_W-1:3];
		end
		if (cmd.calc_mul) begin
			prod1_q <= PROD1_W'(elx_q) * PROD1_W'(RECIP1);
			pl_q    <= PP2_W'(capx[CAPX_LO_W-1:0]) * PP2_W'(RECIP2);
			ph_q    <= PP2_W'(capx[CAPX_W-1:CAPX_LO_W]) * PP2_W'(RECIP2);
		end
		if (cmd.calc_quot) begin
			q1_q <= prod1_q[SHIFT1 +: Q1_W];
			q2_q <= sum2[SHIFT2 +: Q2_W];
		end
		if (cmd.calc_prod) begin
			p_q <= PROD_W'(q1_q) * PROD_W'(q2_q);
		end
		if (cmd.calc_div) begin
			dl_q <= PPL3_W'(px[PX_LO_W-1:0]) * PPL3_W'(RECIP3);
			dh_q <= PPH3_W'(px[PX_W-1:PX_LO_W]) * PPH3_W'(RECIP3);
		end
		if (cmd.calc_refill) begin
			refill_q <= sum3[SHIFT3 +: REFILL_W];
		end
		if (cmd.calc_clamp) begin
			// cap the refilled bucket at one second of bytes
			tok_new_q <= (tok_sum > (TOK_W + 1)'(cap)) ? cap : tok_sum[CAP_W-1:0];
		end
	end

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !cmd.load)
		else $error("bucket write collides with request read");

	a_init_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_init |=> valid_q[slot_q])
		else $error("first packet did not mark bucket valid");

	a_tokens_capped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_verdict |-> (tok_new_q <= cap))
		else $error("token count above bucket capacity at verdict");

endmodule

// File: rtl/tbp_ctrl.sv
// ----------------------------------------------------------------------------
// Token bucket policer controller
// One-hot state machine that sequences the datapath through bucket read,
// then first-packet init or refill arithmetic and verdict, for one request at a time.
// ----------------------------------------------------------------------------
module tbp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_free,
	input  tbp_pkg::dp_status_t status,
	output tbp_pkg::dp_cmd_t    cmd,
	output logic                emit
);
	import tbp_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b00_0000_0001,
		ST_ELAPSED = 10'b00_0000_0010,
		ST_INIT    = 10'b00_0000_0100,
		ST_MUL     = 10'b00_0000_1000,
		ST_QUOT    = 10'b00_0001_0000,
		ST_PROD    = 10'b00_0010_0000,
		ST_DIV     = 10'b00_0100_0000,
		ST_REFILL  = 10'b00_1000_0000,
		ST_CLAMP   = 10'b01_0000_0000,
		ST_VERDICT = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ELAPSED;
				end
			end
			ST_ELAPSED: begin
				if (status.bucket_valid) begin
					cmd.calc_elapsed = 1'b1;
					state_d          = ST_MUL;
				end else begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				// hold until the output register can take the result
				if (out_free) begin
					cmd.wr_init = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.calc_mul = 1'b1;
				state_d      = ST_QUOT;
			end
			ST_QUOT: begin
				cmd.calc_quot = 1'b1;
				state_d       = ST_PROD;
			end
			ST_PROD: begin
				cmd.calc_prod = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.calc_div = 1'b1;
				state_d      = ST_REFILL;
			end
			ST_REFILL: begin
				cmd.calc_refill = 1'b1;
				state_d         = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.calc_clamp = 1'b1;
				state_d        = ST_VERDICT;
			end
			ST_VERDICT: begin
				if (out_free) begin
					cmd.wr_verdict = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign emit = cmd.wr_init | cmd.wr_verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/per_rule_token_bucket_policer_top.sv
// ----------------------------------------------------------------------------
// Per-rule token bucket policer, top level
// Each packet request names a rule, its rate, the time and its length; the
// block answers with pass or drop and the cause.
// ----------------------------------------------------------------------------
// One request is worked at a time. The first packet of a rule loads its
// bucket with one second of bytes; its result is written in the init state
// that follows the bucket-valid check. Any later packet runs the refill
// through a chain of registered multiply and shift steps (elapsed/1000,
// rate/8000, their product, then /1000000) between the bucket read at
// acceptance and the bucket write at the verdict. A result waits in the
// output register while the next request is accepted; the init or verdict
// write stalls only while that register still holds an untaken result.
// Rule indexes wrap modulo RULE_COUNT, and the bucket store holds
// min(RULE_COUNT, 256) entries with valid bits cleared by reset, so no
// clearing pass is needed.
module per_rule_token_bucket_policer_top #(
	parameter int RULE_COUNT = tbp_pkg::RULE_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// rule_index[7:0], rule_rate_bits[47:8], now_ns[111:48], packet_bytes[127:112]
	input  logic [tbp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// pass_packet[0], verdict_cause[2:1], zero fill[7:3]
	output logic [tbp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import tbp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       emit;
	logic       out_free;
	logic       res_pass;
	cause_t     res_cause;

	logic       out_valid_q;
	logic       out_pass_q;
	cause_t     out_cause_q;

	assign out_free = !out_valid_q || m_axis_tready;

	tbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd),
		.emit     (emit)
	);

	tbp_datapath #(
		.RULE_COUNT (RULE_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_tdata  (s_axis_tdata),
		.status    (status),
		.res_pass  (res_pass),
		.res_cause (res_cause)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pass_q  <= res_pass;
			out_cause_q <= res_cause;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - 3)'(0), out_cause_q, out_pass_q};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || m_axis_tready))
		else $error("result loaded over an untaken result");

endmodule
